### rtl/core/wtso_pkg.sv
// ----------------------------------------------------------------------------
// wtso_pkg
// Shared types and constants of the wheel tick speed and odometer block.
// ----------------------------------------------------------------------------
package wtso_pkg;

	// operation codes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	// configuration register indexes
	localparam int            CFG_IDX_W    = 1;
	localparam int            CFG_DATA_W   = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CIRC     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd1;

	localparam int CIRC_W     = 12;
	localparam int INTERVAL_W = 16;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd50;

	localparam int TIME_W   = 32;
	localparam int WIN_W    = 8;
	localparam int LIMIT_W  = 18;   // 255 s * 1000 fits in 18 bits
	localparam int SPEED_W  = 16;
	localparam int INCHES_W = 32;
	localparam int MILES_W  = 17;

	// count * circumference in 1/16 inch
	localparam int INCH_PROD_W = TIME_W + CIRC_W;

	// speed_q8 = n * circ_q4 * 10000 / (11 * elapsed); 0.0176 in/ms per mph folded in
	localparam int SCALE_W = 14;
	localparam logic [SCALE_W-1:0] SPEED_SCALE = 14'd10000;
	localparam int DEN_W = 36;
	localparam logic [DEN_W-1:0] SPEED_DEN_MUL = 36'd11;

	localparam logic [LIMIT_W-1:0] MS_PER_SECOND   = 18'd1000;

	// miles by reciprocal: 63360 = 2^7 * 495, so
	// x / 63360 = ((x >> 7) * ceil(2^34 / 495)) >> 34, exact for any 32-bit x
	localparam int MILE_PRE_SHIFT  = 7;
	localparam int MILE_POST_SHIFT = 34;
	localparam int MILE_RECIP_W    = 26;
	localparam logic [MILE_RECIP_W-1:0] MILE_RECIP = 26'd34706807;
	localparam int MILE_PROD_W = INCHES_W - MILE_PRE_SHIFT + MILE_RECIP_W;

	typedef struct packed {
		logic              operation;
		logic [TIME_W-1:0] now_ms;
		logic [WIN_W-1:0]  window_seconds;
	} in_item_t;

	typedef struct packed {
		logic                tick_accepted;
		logic [SPEED_W-1:0]  speed_mph_q8;
		logic [INCHES_W-1:0] total_inches;
		logic [MILES_W-1:0]  total_miles;
	} out_item_t;

endpackage

### rtl/core/wtso_ram.sv
// ----------------------------------------------------------------------------
// wtso_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wtso_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/wtso_div.sv
// ----------------------------------------------------------------------------
// wtso_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtso_div
	import wtso_pkg::*;
#(
	parameter int NW = 32,
	parameter int DW = 36
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [NW-1:0]    quo_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, quo_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift the dividend out, the quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

### rtl/core/wheel_tick_speed_odometer.sv
// ----------------------------------------------------------------------------
// wheel_tick_speed_odometer
// Wheel tick filter, speed over a time window, and odometer totals.
// ----------------------------------------------------------------------------
// The block handles one item at a time and returns exactly one result per
// item. A tick item (operation 0) is stored when at least min_tick_interval_ms
// have passed since the newest stored tick (or since time zero when the ring
// is empty); a report item (operation 1) walks the timestamp ring back from
// the newest tick and returns the speed in 1/256 mph over the requested
// window. Both give total inches and whole miles taken after the item. Tick
// timestamps live in a RING_DEPTH-entry synchronous RAM; fill count, write
// position and the tick count are flip-flops, so no clearing pass is needed
// after reset. A report runs a speed division only when the walk finds a
// tick in the window and a nonzero elapsed time; a report on an empty ring
// skips the walk. The serial divider is NW bits wide (32 for RING_DEPTH 32).
// The run time of an item is set by the serial divider (one quotient bit per
// cycle, used for speed only; miles come from a reciprocal multiplication)
// and by the ring walk, which reads one entry per cycle. A stalled output
// holds a finished item in its last state until the output register is
// free. in_stall is low only while the block is idle; a finished result
// waits in the output register while the next item is taken in.
// ----------------------------------------------------------------------------
module wheel_tick_speed_odometer
	import wtso_pkg::*;
#(
	parameter int RING_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW     = $clog2(RING_DEPTH);
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int P1_W   = FILL_W + CIRC_W;
	localparam int SPD_NW = P1_W + SCALE_W;
	localparam int NW     = SPD_NW;

	// sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_PRIME   = 4'd1;
	localparam logic [3:0] S_TICK    = 4'd2;
	localparam logic [3:0] S_WALK    = 4'd3;
	localparam logic [3:0] S_MUL1    = 4'd4;
	localparam logic [3:0] S_MUL2    = 4'd5;
	localparam logic [3:0] S_SPDDIV  = 4'd6;
	localparam logic [3:0] S_INCH1   = 4'd7;
	localparam logic [3:0] S_INCH2   = 4'd8;
	localparam logic [3:0] S_MILES   = 4'd9;
	localparam logic [3:0] S_DONE    = 4'd10;

	// configuration registers
	logic [CIRC_W-1:0]     circ_q;
	logic [INTERVAL_W-1:0] min_ivl_q;

	// ring bookkeeping and odometer
	logic [AW-1:0]     head_q;
	logic [FILL_W-1:0] fill_q;
	logic [TIME_W-1:0] count_q;

	// per-item working registers
	logic [3:0]         state_q;
	in_item_t           item_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [FILL_W-1:0]  gone_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [P1_W-1:0]    prod1_q;
	logic               acc_q;
	logic [SPEED_W-1:0] speed_q;
	logic [INCH_PROD_W-1:0] inch_prod_q;
	logic [INCHES_W-1:0]    inches_q;
	logic [MILES_W-1:0]     miles_q;
	logic               div_start_q;
	logic [NW-1:0]      div_num_q;
	logic [DEN_W-1:0]   div_den_q;
	logic               out_valid_q;
	out_item_t          out_q;

	// RAM and divider hookup
	logic              ram_we;
	logic [TIME_W-1:0] ram_rdata;
	logic              div_done;
	logic [NW-1:0]     div_quot;

	// combinational helpers
	logic [AW-1:0]     newest_ptr;
	logic [AW-1:0]     rd_ptr_dec;
	logic [AW-1:0]     head_inc;
	logic [TIME_W-1:0] last_time;
	logic [TIME_W-1:0] since_last;
	logic              tick_ok;
	logic [TIME_W-1:0] walk_elapsed;
	logic              walk_stop_old;
	logic [FILL_W:0]   gone_inc;
	logic              out_free;
	logic [MILE_PROD_W-1:0] mile_prod;

	assign newest_ptr = (head_q == '0) ? AW'(RING_DEPTH - 1) : head_q - 1'b1;
	assign rd_ptr_dec = (rd_ptr_q == '0) ? AW'(RING_DEPTH - 1) : rd_ptr_q - 1'b1;
	assign head_inc   = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;

	// an empty ring counts as a last tick at time zero
	assign last_time  = (fill_q != '0) ? ram_rdata : '0;
	assign since_last = item_q.now_ms - last_time;
	assign tick_ok    = since_last >= {{(TIME_W - INTERVAL_W){1'b0}}, min_ivl_q};

	assign walk_elapsed  = item_q.now_ms - ram_rdata;
	assign walk_stop_old = walk_elapsed >= {{(TIME_W - LIMIT_W){1'b0}}, limit_q};
	assign gone_inc      = {1'b0, gone_q} + 1'b1;

	// whole miles: drop the factor 2^7 of 63360, then multiply by 1/495
	assign mile_prod = MILE_PROD_W'(inches_q[INCHES_W-1:MILE_PRE_SHIFT])
		* MILE_PROD_W'(MILE_RECIP);

	assign ram_we   = (state_q == S_TICK) && tick_ok;
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	wtso_ram #(
		.WIDTH(TIME_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head_q),
		.wdata(item_q.now_ms),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	wtso_div #(
		.NW(NW),
		.DW(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (div_num_q),
		.den   (div_den_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	// Configuration writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q    <= '0;
			min_ivl_q <= INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CIRC:     circ_q    <= cfg_data[CIRC_W-1:0];
				REG_INTERVAL: min_ivl_q <= cfg_data[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// Control: sequencer, ring bookkeeping, tick count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			count_q     <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PRIME;
					end
				end
				S_PRIME: begin
					// newest entry is being read; an empty ring skips the walk
					if (item_q.operation == OP_TICK) begin
						state_q <= S_TICK;
					end else if (fill_q == '0) begin
						state_q <= S_INCH1;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_TICK: begin
					if (tick_ok) begin
						head_q <= head_inc;
						if (fill_q != FILL_W'(RING_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
						if (count_q != '1) begin
							count_q <= count_q + 1'b1;
						end
					end
					state_q <= S_INCH1;
				end
				S_WALK: begin
					if (walk_stop_old || (gone_inc >= {1'b0, fill_q})) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					if ((gone_q == '0) || (elapsed_q == '0)) begin
						state_q <= S_INCH1;
					end else begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					div_start_q <= 1'b1;
					state_q     <= S_SPDDIV;
				end
				S_SPDDIV: begin
					if (div_done) begin
						state_q <= S_INCH1;
					end
				end
				S_INCH1: begin
					state_q <= S_INCH2;
				end
				S_INCH2: begin
					state_q <= S_MILES;
				end
				S_MILES: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					item_q   <= in_item;
					limit_q  <= LIMIT_W'(in_item.window_seconds) * MS_PER_SECOND;
					rd_ptr_q <= newest_ptr;
					gone_q   <= '0;
					acc_q    <= 1'b0;
					speed_q  <= '0;
				end
			end
			S_PRIME: begin
				// prefetch the next older entry
				rd_ptr_q <= rd_ptr_dec;
			end
			S_TICK: begin
				acc_q <= tick_ok;
			end
			S_WALK: begin
				// data holds the entry gone_q back from the newest
				rd_ptr_q  <= rd_ptr_dec;
				elapsed_q <= walk_elapsed;
				if (!walk_stop_old) begin
					gone_q <= gone_inc[FILL_W-1:0];
				end
			end
			S_MUL1: begin
				prod1_q <= P1_W'(gone_q) * P1_W'(circ_q);
			end
			S_MUL2: begin
				div_num_q <= NW'(SPD_NW'(prod1_q) * SPD_NW'(SPEED_SCALE));
				div_den_q <= {{(DEN_W - TIME_W){1'b0}}, elapsed_q} * SPEED_DEN_MUL;
			end
			S_SPDDIV: begin
				if (div_done) begin
					speed_q <= (div_quot[NW-1:SPEED_W] != '0) ? '1 : div_quot[SPEED_W-1:0];
				end
			end
			S_INCH1: begin
				inch_prod_q <= INCH_PROD_W'(count_q) * INCH_PROD_W'(circ_q);
			end
			S_INCH2: begin
				// drop the sixteenths and saturate
				if (inch_prod_q[INCH_PROD_W-1:INCHES_W+4] != '0) begin
					inches_q <= '1;
				end else begin
					inches_q <= inch_prod_q[INCHES_W+3:4];
				end
			end
			S_MILES: begin
				miles_q <= mile_prod[MILE_POST_SHIFT +: MILES_W];
			end
			S_DONE: begin
				if (out_free) begin
					out_q.tick_accepted <= acc_q;
					out_q.speed_mph_q8  <= speed_q;
					out_q.total_inches  <= inches_q;
					out_q.total_miles   <= miles_q;
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_DEPTH))
		else $error("ring fill count beyond ring depth");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the finishing state");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_SPDDIV))
		else $error("divider finished while nobody waits for it");

	a_tick_no_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.tick_accepted) |-> (out_q.speed_mph_q8 == '0))
		else $error("stored tick carries a speed");

endmodule
